// File: design/mf3_pkg.sv
// Package for the 3x3 median filter: constants, codes, shared structs and
// compare helpers. No dependencies; all other files but mf3_ram and mf3_checker use it.
`default_nettype none

package mf3_pkg;

   // Geometry and widths
   localparam int MF3_MAX_WIDTH   = 1024;
   localparam int MF3_PIX_W       = 8;
   localparam int MF3_WIDTH_W     = 11;
   localparam int MF3_HEIGHT_W    = 16;
   localparam int MF3_CSR_DATA_W  = 16;
   localparam int MF3_CSR_INDEX_W = 1;
   localparam int MF3_MIN_DIM     = 3;
   localparam int MF3_QUEUE_DEPTH = 4;

   localparam logic [MF3_WIDTH_W-1:0]  MF3_WIDTH_RESET  = 11'd640;
   localparam logic [MF3_HEIGHT_W-1:0] MF3_HEIGHT_RESET = 16'd480;

   // Register indexes
   localparam logic [MF3_CSR_INDEX_W-1:0] MF3_CSR_IMAGE_WIDTH  = 1'b0;
   localparam logic [MF3_CSR_INDEX_W-1:0] MF3_CSR_IMAGE_HEIGHT = 1'b1;

   // Request opcodes
   localparam logic MF3_OP_PIXEL = 1'b0;
   localparam logic MF3_OP_DRAIN = 1'b1;

   // What one classified request asks the back end to produce
   typedef struct packed {
      logic emit_main;    // result for the window center
      logic emit_border;  // trailing border pixel of the row
      logic interior;     // center takes the median, not a copy
      logic frame_end;    // border result closes the frame
   } mf3_ctrl_type;

   typedef struct packed {
      logic [MF3_PIX_W-1:0] pixel_out;
      logic                 row_end;
      logic                 frame_end;
   } mf3_result_type;

   function automatic logic [MF3_PIX_W-1:0] mf3_lo(input logic [MF3_PIX_W-1:0] a,
                                                   input logic [MF3_PIX_W-1:0] b);
      return (a < b) ? a : b;
   endfunction

   function automatic logic [MF3_PIX_W-1:0] mf3_hi(input logic [MF3_PIX_W-1:0] a,
                                                   input logic [MF3_PIX_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   function automatic logic [MF3_PIX_W-1:0] mf3_mid(input logic [MF3_PIX_W-1:0] a,
                                                    input logic [MF3_PIX_W-1:0] b,
                                                    input logic [MF3_PIX_W-1:0] c);
      return mf3_hi(mf3_lo(a, b), mf3_lo(mf3_hi(a, b), c));
   endfunction

endpackage

`default_nettype wire

// File: design/mf3_req_if.sv
// Request channel of the median filter: valid/ready plus opcode and pixel.
// Depends on mf3_pkg for the pixel width.
`default_nettype none

interface mf3_req_if;
   logic                          valid;
   logic                          ready;
   logic                          opcode;
   logic [mf3_pkg::MF3_PIX_W-1:0] pixel_in;

   modport source (output valid, output opcode, output pixel_in, input ready);
   modport sink   (input valid, input opcode, input pixel_in, output ready);
endinterface

`default_nettype wire

// File: design/mf3_rsp_if.sv
// Response channel of the median filter: valid/ready plus filtered pixel and
// row/frame end flags. Depends on mf3_pkg for the pixel width.
`default_nettype none

interface mf3_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [mf3_pkg::MF3_PIX_W-1:0] pixel_out;
   logic                          row_end;
   logic                          frame_end;

   modport source (output valid, output pixel_out, output row_end, output frame_end,
                   input ready);
   modport sink   (input valid, input pixel_out, input row_end, input frame_end,
                   output ready);
endinterface

`default_nettype wire

// File: design/mf3_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mf3_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              we,
   input  wire logic [ADDR_W-1:0] waddr,
   input  wire logic [WIDTH-1:0]  wdata,
   input  wire logic              re,
   input  wire logic [ADDR_W-1:0] raddr,
   output logic      [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// File: design/mf3_front.sv
// Front end: accepts requests, tracks row/column, classifies each pixel.
// Depends on mf3_pkg and mf3_req_if.
`default_nettype none

module mf3_front #(
   parameter int MAX_WIDTH = mf3_pkg::MF3_MAX_WIDTH,
   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   mf3_req_if.sink                                 req_bus,
   input  wire logic [mf3_pkg::MF3_WIDTH_W-1:0]    image_width,
   input  wire logic [mf3_pkg::MF3_HEIGHT_W-1:0]   image_height,
   input  wire logic                               q_full,
   output logic                                    push,
   output mf3_pkg::mf3_ctrl_type                   push_ctrl,
   output logic      [COL_W-1:0]                   push_addr,
   output logic      [mf3_pkg::MF3_PIX_W-1:0]      push_pixel
);
   import mf3_pkg::*;

   localparam int WEFF_W = $clog2(MAX_WIDTH + 1);
   localparam int EW     = (WEFF_W > MF3_WIDTH_W) ? WEFF_W : MF3_WIDTH_W;

   logic [COL_W-1:0]        col_ff, col_in;
   logic [MF3_HEIGHT_W-1:0] row_ff, row_in;
   logic [EW-1:0]           w_ext, w_eff, col_ext;
   logic [MF3_HEIGHT_W-1:0] h_eff;
   logic                    drain_row, row_done, skip, accept;

   assign req_bus.ready = !q_full;
   assign accept        = req_bus.valid && req_bus.ready;

   // Effective geometry: clamp width to [3, MAX_WIDTH], height to at least 3
   assign w_ext = EW'(image_width);
   always_comb begin
      priority if (w_ext < EW'(MF3_MIN_DIM)) begin
         w_eff = EW'(MF3_MIN_DIM);
      end else if (w_ext > EW'(MAX_WIDTH)) begin
         w_eff = EW'(MAX_WIDTH);
      end else begin
         w_eff = w_ext;
      end
   end
   assign h_eff = (image_height < MF3_HEIGHT_W'(MF3_MIN_DIM)) ?
                  MF3_HEIGHT_W'(MF3_MIN_DIM) : image_height;

   assign col_ext   = EW'(col_ff);
   assign drain_row = row_ff >= h_eff;
   assign row_done  = (col_ext + EW'(1)) >= w_eff;
   // A drain tick outside the drain row is taken and dropped
   assign skip      = (req_bus.opcode == MF3_OP_DRAIN) && !drain_row;
   assign push      = accept && !skip;

   assign push_addr  = col_ff;
   assign push_pixel = drain_row ? '0 : req_bus.pixel_in;

   always_comb begin
      push_ctrl.emit_main   = (row_ff != '0) && (col_ff != '0);
      push_ctrl.emit_border = (row_ff != '0) && row_done;
      push_ctrl.interior    = (row_ff >= MF3_HEIGHT_W'(2)) && !drain_row &&
                              (col_ff >= COL_W'(2)) && (col_ext < w_eff);
      push_ctrl.frame_end   = drain_row;
   end

   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (push) begin
         if (row_done) begin
            col_in = '0;
            row_in = drain_row ? '0 : row_ff + MF3_HEIGHT_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

`default_nettype wire

// File: design/mf3_queue.sv
// Short queue between front and back end, flop-based.
// Depends on mf3_pkg.
`default_nettype none

module mf3_queue #(
   parameter int MAX_WIDTH = mf3_pkg::MF3_MAX_WIDTH,
   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          push,
   input  wire mf3_pkg::mf3_ctrl_type         push_ctrl,
   input  wire logic [COL_W-1:0]              push_addr,
   input  wire logic [mf3_pkg::MF3_PIX_W-1:0] push_pixel,
   output logic                               full,
   input  wire logic                          pop,
   output logic                               head_valid,
   output mf3_pkg::mf3_ctrl_type              head_ctrl,
   output logic      [COL_W-1:0]              head_addr,
   output logic      [mf3_pkg::MF3_PIX_W-1:0] head_pixel
);
   import mf3_pkg::*;

   localparam int PTR_W = $clog2(MF3_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(MF3_QUEUE_DEPTH + 1);

   mf3_ctrl_type         ctrl_ff  [MF3_QUEUE_DEPTH];
   logic [COL_W-1:0]     addr_ff  [MF3_QUEUE_DEPTH];
   logic [MF3_PIX_W-1:0] pixel_ff [MF3_QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0]     count_ff, count_in;

   assign full       = count_ff == CNT_W'(MF3_QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_ctrl  = ctrl_ff[rd_ff];
   assign head_addr  = addr_ff[rd_ff];
   assign head_pixel = pixel_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + PTR_W'(1) : wr_ff;
      rd_in    = pop  ? rd_ff + PTR_W'(1) : rd_ff;
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ctrl_ff[wr_ff]  <= push_ctrl;
         addr_ff[wr_ff]  <= push_addr;
         pixel_ff[wr_ff] <= push_pixel;
      end
   end

endmodule

`default_nettype wire

// File: design/mf3_back.sv
// Back end: line store access, 3x3 window, median network, response buffer.
// Depends on mf3_pkg, mf3_rsp_if and mf3_ram.
`default_nettype none

module mf3_back #(
   parameter int MAX_WIDTH = mf3_pkg::MF3_MAX_WIDTH,
   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          head_valid,
   input  wire mf3_pkg::mf3_ctrl_type         head_ctrl,
   input  wire logic [COL_W-1:0]              head_addr,
   input  wire logic [mf3_pkg::MF3_PIX_W-1:0] head_pixel,
   output logic                               pop,
   mf3_rsp_if.source                          rsp_bus
);
   import mf3_pkg::*;

   localparam int LINE_W = 2 * MF3_PIX_W;

   // Stage 1: line store read in flight
   logic                 v1_ff, v1_in;
   mf3_ctrl_type         ctrl1_ff;
   logic [COL_W-1:0]     addr1_ff;
   logic [MF3_PIX_W-1:0] pix1_ff;
   logic [LINE_W-1:0]    line_rdata;
   logic [MF3_PIX_W-1:0] older_px, newer_px;

   // Stage 2: window
   logic                 v2_ff, v2_in;
   mf3_ctrl_type         ctrl2_ff;
   logic [MF3_PIX_W-1:0] win_ff [9];
   logic [MF3_PIX_W-1:0] win_in [9];

   // Stage 3: column sort
   logic                 v3_ff, v3_in;
   mf3_ctrl_type         ctrl3_ff;
   logic [MF3_PIX_W-1:0] lo3_ff [3];
   logic [MF3_PIX_W-1:0] md3_ff [3];
   logic [MF3_PIX_W-1:0] hi3_ff [3];
   logic [MF3_PIX_W-1:0] center3_ff, border3_ff;

   // Response buffer, two slots
   mf3_result_type       slot0_ff, slot0_in, slot1_ff, slot1_in;
   logic                 sv0_ff, sv0_in, sv1_ff, sv1_in;
   mf3_result_type       main_res, border_res;
   logic [MF3_PIX_W-1:0] median;
   logic                 has_any, buf_free, fire;
   logic                 take4, adv3, adv2;

   // Stage handshake
   assign fire     = rsp_bus.valid && rsp_bus.ready;
   assign buf_free = !sv0_ff || (rsp_bus.ready && !sv1_ff);
   assign has_any  = ctrl3_ff.emit_main || ctrl3_ff.emit_border;
   assign take4    = v3_ff && (!has_any || buf_free);
   assign adv3     = v2_ff && (!v3_ff || take4);
   assign adv2     = v1_ff && (!v2_ff || adv3);
   assign pop      = head_valid && (!v1_ff || adv2);

   assign v1_in = pop  || (v1_ff && !adv2);
   assign v2_in = adv2 || (v2_ff && !adv3);
   assign v3_in = adv3 || (v3_ff && !take4);

   // Line store entry holds {row r-2, row r-1}; rotate on write
   mf3_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_WIDTH)
   ) u_line (
      .clock (clock),
      .we    (adv2),
      .waddr (addr1_ff),
      .wdata ({newer_px, pix1_ff}),
      .re    (pop),
      .raddr (head_addr),
      .rdata (line_rdata)
   );

   assign older_px = line_rdata[LINE_W-1:MF3_PIX_W];
   assign newer_px = line_rdata[MF3_PIX_W-1:0];

   // Shift window left, new column on the right
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[3*k]     = win_ff[3*k+1];
         win_in[3*k + 1] = win_ff[3*k+2];
      end
      win_in[2] = older_px;
      win_in[5] = newer_px;
      win_in[8] = pix1_ff;
   end

   assign median = mf3_mid(mf3_hi(mf3_hi(lo3_ff[0], lo3_ff[1]), lo3_ff[2]),
                           mf3_mid(md3_ff[0], md3_ff[1], md3_ff[2]),
                           mf3_lo(mf3_lo(hi3_ff[0], hi3_ff[1]), hi3_ff[2]));

   always_comb begin
      main_res.pixel_out   = ctrl3_ff.interior ? median : center3_ff;
      main_res.row_end     = 1'b0;
      main_res.frame_end   = 1'b0;
      border_res.pixel_out = border3_ff;
      border_res.row_end   = 1'b1;
      border_res.frame_end = ctrl3_ff.frame_end;
   end

   always_comb begin
      slot0_in = slot0_ff;
      slot1_in = slot1_ff;
      sv0_in   = sv0_ff;
      sv1_in   = sv1_ff;
      if (take4 && has_any) begin
         slot0_in = ctrl3_ff.emit_main ? main_res : border_res;
         slot1_in = border_res;
         sv0_in   = 1'b1;
         sv1_in   = ctrl3_ff.emit_main && ctrl3_ff.emit_border;
      end else if (fire) begin
         slot0_in = slot1_ff;
         sv0_in   = sv1_ff;
         sv1_in   = 1'b0;
      end
   end

   assign rsp_bus.valid     = sv0_ff;
   assign rsp_bus.pixel_out = slot0_ff.pixel_out;
   assign rsp_bus.row_end   = slot0_ff.row_end;
   assign rsp_bus.frame_end = slot0_ff.frame_end;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         sv0_ff <= 1'b0;
         sv1_ff <= 1'b0;
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         v1_ff  <= v1_in;
         v2_ff  <= v2_in;
         v3_ff  <= v3_in;
         sv0_ff <= sv0_in;
         sv1_ff <= sv1_in;
         if (adv2) begin
            win_ff <= win_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         ctrl1_ff <= head_ctrl;
         addr1_ff <= head_addr;
         pix1_ff  <= head_pixel;
      end
      if (adv2) begin
         ctrl2_ff <= ctrl1_ff;
      end
      if (adv3) begin
         ctrl3_ff   <= ctrl2_ff;
         center3_ff <= win_ff[4];
         border3_ff <= win_ff[5];
         for (int j = 0; j < 3; j++) begin
            lo3_ff[j] <= mf3_lo(mf3_lo(win_ff[j], win_ff[3+j]), win_ff[6+j]);
            hi3_ff[j] <= mf3_hi(mf3_hi(win_ff[j], win_ff[3+j]), win_ff[6+j]);
            md3_ff[j] <= mf3_mid(win_ff[j], win_ff[3+j], win_ff[6+j]);
         end
      end
      slot0_ff <= slot0_in;
      slot1_ff <= slot1_in;
   end

endmodule

`default_nettype wire

// File: design/median_filter_3x3.sv
// Top level of the streaming 3x3 median filter: CSRs, front end, queue and
// back end. Depends on mf3_pkg, mf3_req_if, mf3_rsp_if and the mf3_ blocks.
//
// Streaming 3x3 median filter for 8-bit grey pixels in raster order. Each
// request carries one pixel (opcode pixel) or a drain tick (opcode drain).
// For every interior pixel the block returns the exact median of its 3x3
// neighbourhood; first/last rows and columns are copied through. Results
// run one line and one pixel behind the input: the request at (r, c) yields
// the result for (r-1, c-1), and the last request of a row also yields the
// border pixel (r-1, width-1) flagged with row_end. After the last pixel of
// a frame, send one row of requests (any opcode, image_width of them) to
// drain the final row; its last border result carries frame_end. Drain
// ticks sent before the drain row are accepted and dropped. Throughput is
// one request per clock while the queue is not full. The row-end request
// yields two responses and the column-0 request right behind it yields
// none, so responses also keep pace at one per clock; the four-entry queue
// between front and back end lets the request side keep going while the
// response side stalls. A request passes the queue, line store read,
// window, column sort and response register on its way out. Both line stores
// share one RAM of MAX_WIDTH x 16 bits with one read and one write port.
// Write image_width (index 0) and image_height (index 1) only while the
// block is idle; width is clamped to [3, MAX_WIDTH], height to at least 3.
`default_nettype none

module median_filter_3x3 #(
   parameter int MAX_WIDTH = mf3_pkg::MF3_MAX_WIDTH
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   mf3_req_if.sink                                  req_bus,
   mf3_rsp_if.source                                rsp_bus,
   input  wire logic                                csr_we,
   input  wire logic [mf3_pkg::MF3_CSR_INDEX_W-1:0] csr_index,
   input  wire logic [mf3_pkg::MF3_CSR_DATA_W-1:0]  csr_wdata
);
   import mf3_pkg::*;

   localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

   logic [MF3_WIDTH_W-1:0]  image_width_ff;
   logic [MF3_HEIGHT_W-1:0] image_height_ff;

   // Front to queue
   logic                 push, q_full;
   mf3_ctrl_type         push_ctrl;
   logic [COL_W-1:0]     push_addr;
   logic [MF3_PIX_W-1:0] push_pixel;

   // Queue to back end
   logic                 pop, head_valid;
   mf3_ctrl_type         head_ctrl;
   logic [COL_W-1:0]     head_addr;
   logic [MF3_PIX_W-1:0] head_pixel;

   // Configuration registers: take the write at once, no read-back
   always_ff @(posedge clock) begin
      if (reset) begin
         image_width_ff  <= MF3_WIDTH_RESET;
         image_height_ff <= MF3_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            MF3_CSR_IMAGE_WIDTH: begin
               image_width_ff <= csr_wdata[MF3_WIDTH_W-1:0];
            end
            MF3_CSR_IMAGE_HEIGHT: begin
               image_height_ff <= csr_wdata[MF3_HEIGHT_W-1:0];
            end
            default: begin
               image_width_ff <= image_width_ff;
            end
         endcase
      end
   end

   // Classify requests and advance the raster counters
   mf3_front #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req_bus      (req_bus),
      .image_width  (image_width_ff),
      .image_height (image_height_ff),
      .q_full       (q_full),
      .push         (push),
      .push_ctrl    (push_ctrl),
      .push_addr    (push_addr),
      .push_pixel   (push_pixel)
   );

   // Decouple front from back so each side can stall on its own
   mf3_queue #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ctrl  (push_ctrl),
      .push_addr  (push_addr),
      .push_pixel (push_pixel),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_ctrl  (head_ctrl),
      .head_addr  (head_addr),
      .head_pixel (head_pixel)
   );

   // Line store, window, median network and response buffer
   mf3_back #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_ctrl  (head_ctrl),
      .head_addr  (head_addr),
      .head_pixel (head_pixel),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire

// File: design/mf3_checker.sv
// Port-level checks for the median filter top level, attached by bind.
// Depends on median_filter_3x3 and its response channel.
`default_nettype none

module mf3_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [7:0] rsp_pixel_out,
   input wire logic       rsp_row_end,
   input wire logic       rsp_frame_end
);

   // A frame ends only on a row-end response
   a_frame_on_row_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> rsp_row_end)
      else $error("frame_end without row_end");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_pixel_out) && $stable(rsp_row_end) &&
          $stable(rsp_frame_end)))
      else $error("response changed while stalled");

   // Nothing leaves right after reset
   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // Two row ends never come back to back: a center result always precedes
   a_no_double_row_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_row_end) |=> !(rsp_valid && rsp_row_end))
      else $error("back-to-back row_end responses");

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_bus.valid),
   .rsp_ready     (rsp_bus.ready),
   .rsp_pixel_out (rsp_bus.pixel_out),
   .rsp_row_end   (rsp_bus.row_end),
   .rsp_frame_end (rsp_bus.frame_end)
);

`default_nettype wire
